### rtl/core/bayer_ppg_demosaic_top_defines.svh
// Assertion macros shared by the demosaic checker.
`ifndef BAYER_PPG_DEMOSAIC_TOP_DEFINES_SVH
`define BAYER_PPG_DEMOSAIC_TOP_DEFINES_SVH

// Same-edge implication, masked while reset is asserted.
`define BPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-edge implication, masked while reset is asserted.
`define BPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold on the edge after a reset edge.
`define BPD_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) else $error(msg);

`endif

### rtl/core/bpd_pkg.sv
// Types, constants and helper functions of the Bayer demosaic block.
`timescale 1ns / 1ps
package bpd_pkg;

    // Port widths
    localparam int SAMPLE_W   = 8;
    localparam int PIXEL_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Reset values of the frame size registers
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Line ring and output lag
    localparam int RING_BITS = 3;
    localparam int LAG_ROWS  = 3;

    localparam logic signed [11:0] PIX_MAX = 12'sd255;

    // Neighbor taps of an output pixel
    localparam int RAW_SLOTS = 13;
    localparam int R_C = 0, R_W = 1, R_E = 2, R_N = 3, R_S = 4;
    localparam int R_NW = 5, R_NE = 6, R_SW = 7, R_SE = 8;
    localparam int R_NW2 = 9, R_NE2 = 10, R_SW2 = 11, R_SE2 = 12;
    localparam logic signed [2:0] RAW_DX [RAW_SLOTS] = '{
        3'sd0, -3'sd1, 3'sd1, 3'sd0, 3'sd0, -3'sd1, 3'sd1, -3'sd1, 3'sd1,
        -3'sd2, 3'sd2, -3'sd2, 3'sd2};
    localparam logic signed [2:0] RAW_DY [RAW_SLOTS] = '{
        3'sd0, 3'sd0, 3'sd0, -3'sd1, 3'sd1, -3'sd1, -3'sd1, 3'sd1, 3'sd1,
        -3'sd2, -3'sd2, 3'sd2, 3'sd2};

    // Green points around an output pixel (same order as the first nine taps)
    localparam int GRN_JOBS = 9;
    localparam logic signed [2:0] GOFF_DX [GRN_JOBS] = '{
        3'sd0, -3'sd1, 3'sd1, 3'sd0, 3'sd0, -3'sd1, 3'sd1, -3'sd1, 3'sd1};
    localparam logic signed [2:0] GOFF_DY [GRN_JOBS] = '{
        3'sd0, 3'sd0, 3'sd0, -3'sd1, 3'sd1, -3'sd1, -3'sd1, 3'sd1, 3'sd1};

    // Taps of one green estimate
    localparam int GRD_SLOTS = 9;
    localparam int K_C = 0, K_N = 1, K_E = 2, K_W = 3, K_S = 4;
    localparam int K_U = 5, K_D = 6, K_L = 7, K_R = 8;
    localparam logic signed [2:0] GRD_DX [GRD_SLOTS] = '{
        3'sd0, 3'sd0, 3'sd2, -3'sd2, 3'sd0, 3'sd0, 3'sd0, -3'sd1, 3'sd1};
    localparam logic signed [2:0] GRD_DY [GRD_SLOTS] = '{
        3'sd0, -3'sd2, 3'sd0, 3'sd0, 3'sd2, -3'sd1, 3'sd1, 3'sd0, 3'sd0};

    // Gradient directions
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_W = 2'd2;
    localparam logic [1:0] DIR_S = 2'd3;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_RAW   = 12'b0000_0000_0010,
        S_GSET  = 12'b0000_0000_0100,
        S_GRD   = 12'b0000_0000_1000,
        S_GWAIT = 12'b0000_0001_0000,
        S_GA    = 12'b0000_0010_0000,
        S_GB    = 12'b0000_0100_0000,
        S_MIX   = 12'b0000_1000_0000,
        S_HSET  = 12'b0001_0000_0000,
        S_DIV   = 12'b0010_0000_0000,
        S_HEND  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } bpd_state_t;

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [7:0] clip_u8(input logic signed [11:0] v);
        logic [7:0] r;
        if (v < 12'sd0)
            r = 8'd0;
        else if (v > PIX_MAX)
            r = 8'hFF;
        else
            r = v[7:0];
        return r;
    endfunction

    // Lowest of four gradients, ties go to the later one
    function automatic logic [1:0] pick4(input logic [9:0] g0, input logic [9:0] g1,
                                         input logic [9:0] g2, input logic [9:0] g3);
        logic [1:0] i;
        logic [1:0] j;
        logic [9:0] vi;
        logic [9:0] vj;
        i  = (g0 < g1) ? DIR_N : DIR_E;
        vi = (g0 < g1) ? g0 : g1;
        j  = (g2 < g3) ? DIR_W : DIR_S;
        vj = (g2 < g3) ? g2 : g3;
        return (vi < vj) ? i : j;
    endfunction

endpackage

### rtl/core/bayer_ppg_demosaic_top.sv
// Bayer demosaic top level: line memory, pixel sequencer and hue divider.
// Sequencing: an item that completes a pixel keeps s_tready low while the pixel is built, plus any
// output stall (13 tap reads, 9 green estimates, a diagonal select, one or two hue steps and
// the output step); the pixel shows on m_tvalid as s_tready returns high. Items that yield no
// pixel leave s_tready high. The single memory read port sets this.
// Reset (aresetn low, synchronous): counters and handshakes clear, size goes to
// 640 x 480; the line memory keeps its contents and is not cleared.
`timescale 1ns / 1ps
module bayer_ppg_demosaic_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bpd_pkg::SAMPLE_W-1:0]  s_tdata,   // [7:0] sample
    input  logic                          s_tuser,   // [0] flush
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bpd_pkg::PIXEL_W-1:0]   m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic                          m_tlast,   // frame_end
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bpd_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int SXW   = XW + 2;
    localparam int SYW   = YW + 2;
    localparam int AW    = RING_BITS + XW;
    localparam int DEPTH = 1 << AW;

    bpd_state_t state_reg;

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [XW-1:0]   in_col_reg, out_col_reg;
    logic [HW-1:0]   in_row_reg, out_row_reg;
    logic [XW-1:0]   px_x_reg;
    logic [YW-1:0]   px_y_reg;
    logic            fe_reg;

    logic [WW-1:0] cur_w;
    logic [HW-1:0] cur_h;

    // Sequencer counters
    logic [3:0] slot_reg;
    logic [3:0] job_reg;
    logic       pass_reg;
    logic [3:0] div_cnt_reg;

    // Memory read pipeline
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic          rd_pend_reg, rd_grn_reg;
    logic [3:0]    rd_slot_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en, rd_issue;

    // Gathered taps and results
    logic [7:0] raw_reg [RAW_SLOTS];
    logic [7:0] nbr_reg [GRD_SLOTS];
    logic [7:0] grn_reg [GRN_JOBS];
    logic [7:0] hue_reg [2];
    logic [XW-1:0] gx_reg;
    logic [YW-1:0] gy_reg;
    logic [1:0]    dir_reg;
    logic          sel_ne_reg;

    // Hue unit
    logic [15:0]        quo_reg;
    logic [7:0]         rem_reg, den_reg, v1_reg;
    logic               qneg_reg, mono_reg;
    logic signed [11:0] alt_reg;

    logic [7:0] m_r_reg, m_g_reg, m_b_reg;
    logic       m_tlast_reg, m_tvalid_reg;

    logic accept, out_free, green_site;

    // Effective frame size
    always_comb begin
        if (frame_width_reg == '0)
            cur_w = WW'(1);
        else if (int'(frame_width_reg) > MAX_WIDTH)
            cur_w = WW'(MAX_WIDTH);
        else
            cur_w = WW'(frame_width_reg);
        if (frame_height_reg == '0)
            cur_h = HW'(1);
        else if (int'(frame_height_reg) > MAX_HEIGHT)
            cur_h = HW'(MAX_HEIGHT);
        else
            cur_h = HW'(frame_height_reg);
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign green_site = px_x_reg[0] ^ px_y_reg[0];

    // Position bookkeeping for an accepted item
    logic          wrap, emit_go, fe_n;
    logic [XW-1:0] ic, oc, ic_n, oc_n;
    logic [HW-1:0] ir, orw, ir_n, or_n;
    always_comb begin
        wrap = (in_row_reg >= cur_h);
        if (s_tuser) begin
            ic      = in_col_reg;
            ir      = in_row_reg;
            oc      = out_col_reg;
            orw     = out_row_reg;
            ic_n    = ic;
            ir_n    = ir;
            emit_go = wrap && (out_row_reg < cur_h);
        end else begin
            ic  = wrap ? '0 : in_col_reg;
            ir  = wrap ? '0 : in_row_reg;
            oc  = wrap ? '0 : out_col_reg;
            orw = wrap ? '0 : out_row_reg;
            if (int'(ic) + 1 >= int'(cur_w)) begin
                ic_n = '0;
                ir_n = ir + HW'(1);
            end else begin
                ic_n = ic + XW'(1);
                ir_n = ir;
            end
            emit_go = (ir > HW'(LAG_ROWS)) || ((ir == HW'(LAG_ROWS)) && (ic != '0));
        end
        oc_n = oc;
        or_n = orw;
        fe_n = 1'b0;
        if (emit_go) begin
            if (int'(oc) + 1 >= int'(cur_w)) begin
                oc_n = '0;
                or_n = orw + HW'(1);
            end else begin
                oc_n = oc + XW'(1);
            end
            if (or_n >= cur_h) begin
                fe_n = 1'b1;
                ic_n = '0;
                ir_n = '0;
                oc_n = '0;
                or_n = '0;
            end
        end
    end

    // Address generator: base point plus tap offset, clamped into the frame
    logic [XW-1:0]         bx, cx;
    logic [YW-1:0]         by, cy;
    logic signed [2:0]     dx, dy;
    logic signed [SXW-1:0] sx;
    logic signed [SYW-1:0] sy;
    always_comb begin
        if (state_reg == S_GSET) begin
            bx = px_x_reg;
            by = px_y_reg;
            dx = GOFF_DX[job_reg];
            dy = GOFF_DY[job_reg];
        end else if (state_reg == S_GRD) begin
            bx = gx_reg;
            by = gy_reg;
            dx = GRD_DX[slot_reg];
            dy = GRD_DY[slot_reg];
        end else begin
            bx = px_x_reg;
            by = px_y_reg;
            dx = RAW_DX[slot_reg];
            dy = RAW_DY[slot_reg];
        end
        sx = $signed({2'b00, bx}) + SXW'(dx);
        sy = $signed({2'b00, by}) + SYW'(dy);
        if (sx[SXW-1])
            cx = '0;
        else if (sx >= $signed(SXW'(cur_w)))
            cx = XW'(cur_w - WW'(1));
        else
            cx = sx[XW-1:0];
        if (sy[SYW-1])
            cy = '0;
        else if (sy >= $signed(SYW'(cur_h)))
            cy = YW'(cur_h - HW'(1));
        else
            cy = sy[YW-1:0];
    end

    assign rd_addr  = {cy[RING_BITS-1:0], cx};
    assign wr_addr  = {ir[RING_BITS-1:0], ic};
    assign wr_en    = accept && !s_tuser;
    assign rd_issue = (state_reg == S_RAW) || (state_reg == S_GRD);

    // Line memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_tdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Green estimate, gradient step
    logic [9:0] gr0, gr1, gr2, gr3;
    always_comb begin
        gr0 = 10'({absdiff(nbr_reg[K_C], nbr_reg[K_N]), 1'b0})
            + 10'(absdiff(nbr_reg[K_U], nbr_reg[K_D]));
        gr1 = 10'({absdiff(nbr_reg[K_C], nbr_reg[K_E]), 1'b0})
            + 10'(absdiff(nbr_reg[K_L], nbr_reg[K_R]));
        gr2 = 10'({absdiff(nbr_reg[K_C], nbr_reg[K_W]), 1'b0})
            + 10'(absdiff(nbr_reg[K_L], nbr_reg[K_R]));
        gr3 = 10'({absdiff(nbr_reg[K_C], nbr_reg[K_S]), 1'b0})
            + 10'(absdiff(nbr_reg[K_U], nbr_reg[K_D]));
    end

    // Green estimate, interpolation step
    logic [7:0]         ga, gb, gd;
    logic signed [11:0] sa, sb, sc, sd, gnum, gq;
    logic [7:0]         gval;
    always_comb begin
        case (dir_reg)
            DIR_N: begin ga = nbr_reg[K_U]; gb = nbr_reg[K_D]; gd = nbr_reg[K_N]; end
            DIR_E: begin ga = nbr_reg[K_R]; gb = nbr_reg[K_L]; gd = nbr_reg[K_E]; end
            DIR_W: begin ga = nbr_reg[K_L]; gb = nbr_reg[K_R]; gd = nbr_reg[K_W]; end
            default: begin ga = nbr_reg[K_D]; gb = nbr_reg[K_U]; gd = nbr_reg[K_S]; end
        endcase
        sa   = $signed(12'(ga));
        sb   = $signed(12'(gb));
        sc   = $signed(12'(nbr_reg[K_C]));
        sd   = $signed(12'(gd));
        gnum = (sa <<< 1) + sa + sb + sc - sd;
        gq   = (gnum + ((gnum < 12'sd0) ? 12'sd3 : 12'sd0)) >>> 2;
        gval = (gx_reg[0] ^ gy_reg[0]) ? nbr_reg[K_C] : clip_u8(gq);
    end

    // Diagonal gradients at red and blue sites
    logic [10:0] dne, dnw;
    always_comb begin
        dne = 11'(absdiff(raw_reg[R_NE], raw_reg[R_SW]))
            + 11'(absdiff(raw_reg[R_NE2], raw_reg[R_C]))
            + 11'(absdiff(raw_reg[R_C], raw_reg[R_SW2]))
            + 11'(absdiff(grn_reg[R_NE], grn_reg[R_C]))
            + 11'(absdiff(grn_reg[R_C], grn_reg[R_SW]));
        dnw = 11'(absdiff(raw_reg[R_NW], raw_reg[R_SE]))
            + 11'(absdiff(raw_reg[R_NW2], raw_reg[R_C]))
            + 11'(absdiff(raw_reg[R_C], raw_reg[R_SE2]))
            + 11'(absdiff(grn_reg[R_NW], grn_reg[R_C]))
            + 11'(absdiff(grn_reg[R_C], grn_reg[R_SE]));
    end

    // Hue transit operands
    logic [7:0] l1, l2, l3, v1, v3;
    always_comb begin
        if (green_site) begin
            l2 = raw_reg[R_C];
            if (!pass_reg) begin
                l1 = grn_reg[R_W]; l3 = grn_reg[R_E];
                v1 = raw_reg[R_W]; v3 = raw_reg[R_E];
            end else begin
                l1 = grn_reg[R_N]; l3 = grn_reg[R_S];
                v1 = raw_reg[R_N]; v3 = raw_reg[R_S];
            end
        end else begin
            l2 = grn_reg[R_C];
            if (sel_ne_reg) begin
                l1 = grn_reg[R_NE]; l3 = grn_reg[R_SW];
                v1 = raw_reg[R_NE]; v3 = raw_reg[R_SW];
            end else begin
                l1 = grn_reg[R_NW]; l3 = grn_reg[R_SE];
                v1 = raw_reg[R_NW]; v3 = raw_reg[R_SE];
            end
        end
    end

    // Hue setup: signs, magnitudes, product and the averaged fallback
    logic signed [8:0]  dv, dl, dd;
    logic [7:0]         mv, ml, md, vsum, lavg;
    logic signed [9:0]  ldev, lhalf;
    logic               mono;
    always_comb begin
        dv    = $signed({1'b0, v3}) - $signed({1'b0, v1});
        dl    = $signed({1'b0, l2}) - $signed({1'b0, l1});
        dd    = $signed({1'b0, l3}) - $signed({1'b0, l1});
        mv    = dv[8] ? 8'(-dv) : dv[7:0];
        ml    = dl[8] ? 8'(-dl) : dl[7:0];
        md    = dd[8] ? 8'(-dd) : dd[7:0];
        mono  = ((l1 < l2) && (l2 < l3)) || ((l1 > l2) && (l2 > l3));
        vsum  = 8'((9'(v1) + 9'(v3)) >> 1);
        lavg  = 8'((9'(l1) + 9'(l3)) >> 1);
        ldev  = $signed({2'b00, l2}) - $signed({2'b00, lavg});
        lhalf = (ldev + ((ldev < 10'sd0) ? 10'sd1 : 10'sd0)) >>> 1;
    end

    // Divider step and hue result
    logic [8:0]         dsh;
    logic               dbit;
    logic signed [11:0] qs, hval;
    always_comb begin
        dsh  = {rem_reg, quo_reg[15]};
        dbit = (dsh >= {1'b0, den_reg});
        qs   = $signed(12'(quo_reg[8:0]));
        hval = mono_reg ? ($signed(12'(v1_reg)) + (qneg_reg ? -qs : qs)) : alt_reg;
    end

    // Pixel assembly
    logic [7:0] pr, pg, pb;
    always_comb begin
        if (green_site) begin
            pg = raw_reg[R_C];
            pr = px_y_reg[0] ? hue_reg[1] : hue_reg[0];
            pb = px_y_reg[0] ? hue_reg[0] : hue_reg[1];
        end else begin
            pg = grn_reg[R_C];
            pr = px_y_reg[0] ? hue_reg[0] : raw_reg[R_C];
            pb = px_y_reg[0] ? raw_reg[R_C] : hue_reg[0];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            slot_reg         <= '0;
            job_reg          <= '0;
            pass_reg         <= 1'b0;
            div_cnt_reg      <= '0;
            rd_pend_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            rd_pend_reg <= rd_issue;
            if (state_reg == S_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        frame_width_reg <= cfg_data[FW_W-1:0];
                        in_col_reg <= '0; in_row_reg <= '0;
                        out_col_reg <= '0; out_row_reg <= '0;
                    end
                    REG_FRAME_HEIGHT: begin
                        frame_height_reg <= cfg_data[FH_W-1:0];
                        in_col_reg <= '0; in_row_reg <= '0;
                        out_col_reg <= '0; out_row_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (accept) begin
                in_col_reg  <= ic_n;
                in_row_reg  <= ir_n;
                out_col_reg <= oc_n;
                out_row_reg <= or_n;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept && emit_go && !cfg_valid) begin
                        state_reg <= S_RAW;
                        slot_reg  <= '0;
                    end
                end
                S_RAW: begin
                    if (slot_reg == 4'(RAW_SLOTS - 1)) begin
                        state_reg <= S_GSET;
                        slot_reg  <= '0;
                        job_reg   <= '0;
                    end else begin
                        slot_reg <= slot_reg + 4'd1;
                    end
                end
                S_GSET: begin
                    state_reg <= S_GRD;
                    slot_reg  <= '0;
                end
                S_GRD: begin
                    if (slot_reg == 4'(GRD_SLOTS - 1))
                        state_reg <= S_GWAIT;
                    else
                        slot_reg <= slot_reg + 4'd1;
                end
                S_GWAIT: state_reg <= S_GA;
                S_GA:    state_reg <= S_GB;
                S_GB: begin
                    if (job_reg == 4'(GRN_JOBS - 1)) begin
                        state_reg <= S_MIX;
                    end else begin
                        job_reg   <= job_reg + 4'd1;
                        state_reg <= S_GSET;
                    end
                end
                S_MIX: begin
                    pass_reg  <= 1'b0;
                    state_reg <= S_HSET;
                end
                S_HSET: begin
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV: begin
                    if (!mono_reg || div_cnt_reg == 4'd15)
                        state_reg <= S_HEND;
                    else
                        div_cnt_reg <= div_cnt_reg + 4'd1;
                end
                S_HEND: begin
                    if (green_site && !pass_reg) begin
                        pass_reg  <= 1'b1;
                        state_reg <= S_HSET;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rd_grn_reg  <= (state_reg == S_GRD);
        rd_slot_reg <= slot_reg;
        if (rd_pend_reg) begin
            if (rd_grn_reg)
                nbr_reg[rd_slot_reg] <= rdata_reg;
            else
                raw_reg[rd_slot_reg] <= rdata_reg;
        end
        if (state_reg == S_IDLE && accept && emit_go) begin
            px_x_reg <= oc;
            px_y_reg <= orw[YW-1:0];
            fe_reg   <= fe_n;
        end
        if (state_reg == S_GSET) begin
            gx_reg <= cx;
            gy_reg <= cy;
        end
        if (state_reg == S_GA)
            dir_reg <= pick4(gr0, gr1, gr2, gr3);
        if (state_reg == S_GB)
            grn_reg[job_reg] <= gval;
        if (state_reg == S_MIX)
            sel_ne_reg <= (dne < dnw);
        if (state_reg == S_HSET) begin
            quo_reg  <= mv * ml;
            den_reg  <= md;
            rem_reg  <= '0;
            qneg_reg <= dv[8] ^ dl[8] ^ dd[8];
            mono_reg <= mono;
            v1_reg   <= v1;
            alt_reg  <= $signed(12'(vsum)) + 12'(lhalf);
        end
        if (state_reg == S_DIV && mono_reg) begin
            rem_reg <= dbit ? 8'(dsh - {1'b0, den_reg}) : dsh[7:0];
            quo_reg <= {quo_reg[14:0], dbit};
        end
        if (state_reg == S_HEND)
            hue_reg[pass_reg] <= clip_u8(hval);
        if (state_reg == S_OUT && out_free) begin
            m_r_reg     <= pr;
            m_g_reg     <= pg;
            m_b_reg     <= pb;
            m_tlast_reg <= fe_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_b_reg, m_g_reg, m_r_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/core/bpd_checker.sv
// Port-level checker for the demosaic top level, with its bind.
`timescale 1ns / 1ps
`include "bayer_ppg_demosaic_top_defines.svh"
module bpd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bpd_pkg::PIXEL_W-1:0] m_tdata,
    input logic                        m_tlast
);
    import bpd_pkg::*;

    // A stalled item stays offered
    `BPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
    // A stalled item keeps its payload
    `BPD_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "output payload changed while stalled")
    // A new pixel only appears after the engine held off input
    `BPD_ASSERT_NOW(a_out_from_engine, $rose(m_tvalid), $past(!s_tready), "pixel appeared without a busy engine")
    // Reset leaves the block empty and ready
    `BPD_ASSERT_RST(a_reset_state, !m_tvalid && s_tready, "block not idle after reset")

endmodule

bind bayer_ppg_demosaic_top bpd_checker u_bpd_checker (.*);

### sim/tb_bayer_ppg_demosaic_top.sv
// Testbench of the Bayer demosaic top level: own pixel predictor, random stream, result check.
`timescale 1ns / 1ps
module tb_bayer_ppg_demosaic_top;
    import bpd_pkg::*;

    localparam int MAXW = 2048;
    localparam int MAXH = 4096;
    localparam int SETTLE = 220;   // longer than the slowest pixel of the block

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pixel_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;   // [7:0] sample
    logic                  s_tuser;   // [0] flush
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIXEL_W-1:0]    m_tdata;   // [7:0] red, [15:8] green, [23:16] blue
    logic                  m_tlast;   // frame_end
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bayer_ppg_demosaic_top DUT (.*);

    // Predictor state
    bit [7:0] line_mem [RING_BITS == 3 ? 8*MAXW : 8*MAXW];
    int       width_reg, height_reg, act_w, act_h;
    int       in_col, in_row, out_col, out_row;
    pixel_t   pixels_due [$];
    int       fail_count;
    int       items_sent;
    bit       idle_on;
    int       hold_cnt;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #50_000_000;
        $display("bayer_ppg_demosaic_top verification failed");
        $finish;
    end

    function automatic int absi(input int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int clamp_px(input int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    function automatic logic [7:0] rnd_px();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int raw_px(input int x, input int y);
        if (x < 0) x = 0;
        if (x >= act_w) x = act_w - 1;
        if (y < 0) y = 0;
        if (y >= act_h) y = act_h - 1;
        return line_mem[(y & 7) * MAXW + x];
    endfunction

    // Effective frame size from the register values
    function automatic void update_size();
        act_w = (width_reg == 0) ? 1 : (width_reg > MAXW ? MAXW : width_reg);
        act_h = (height_reg == 0) ? 1 : (height_reg > MAXH ? MAXH : height_reg);
    endfunction

    // Hue transit between two chroma values guided by three lumas
    function automatic int hue_transit(input int l1, input int l2, input int l3,
                                       input int v1, input int v3);
        if ((l1 < l2 && l2 < l3) || (l1 > l2 && l2 > l3))
            return v1 + (v3 - v1) * (l2 - l1) / (l3 - l1);
        return (v1 + v3) / 2 + (l2 - (l1 + l3) / 2) / 2;
    endfunction

    // Green estimate, lowest of four gradients, ties to the later direction
    function automatic int green_est(input int x, input int y);
        int c, n, e, w, s, gu, gd, gl, gr, t, i, j, k;
        int gv [4];
        if (x < 0) x = 0;
        if (x >= act_w) x = act_w - 1;
        if (y < 0) y = 0;
        if (y >= act_h) y = act_h - 1;
        c = raw_px(x, y);
        if (((x + y) & 1) != 0) return c;
        n = raw_px(x, y - 2); e = raw_px(x + 2, y);
        w = raw_px(x - 2, y); s = raw_px(x, y + 2);
        gu = raw_px(x, y - 1); gd = raw_px(x, y + 1);
        gl = raw_px(x - 1, y); gr = raw_px(x + 1, y);
        gv[0] = absi(c - n) * 2 + absi(gu - gd);
        gv[1] = absi(c - e) * 2 + absi(gl - gr);
        gv[2] = absi(c - w) * 2 + absi(gl - gr);
        gv[3] = absi(c - s) * 2 + absi(gu - gd);
        i = (gv[0] < gv[1]) ? 0 : 1;
        j = (gv[2] < gv[3]) ? 2 : 3;
        k = (gv[i] < gv[j]) ? i : j;
        case (k)
            0: t = (gu * 3 + gd + c - n) / 4;
            1: t = (gr * 3 + gl + c - e) / 4;
            2: t = (gl * 3 + gr + c - w) / 4;
            default: t = (gd * 3 + gu + c - s) / 4;
        endcase
        return clamp_px(t);
    endfunction

    // Full pixel at the output position, then advance it
    function automatic void emit_pixel();
        int x, y, c, r, g, b, hh, vv, dne, dnw, v, g0;
        int o7, o9, o17, o19, s1, s5, s21, s25, g7, g9, g17, g19;
        pixel_t p;
        x = out_col;
        y = out_row;
        c = raw_px(x, y);
        if (((x + y) & 1) != 0) begin
            hh = hue_transit(green_est(x - 1, y), c, green_est(x + 1, y),
                             raw_px(x - 1, y), raw_px(x + 1, y));
            vv = hue_transit(green_est(x, y - 1), c, green_est(x, y + 1),
                             raw_px(x, y - 1), raw_px(x, y + 1));
            g = c;
            if ((y & 1) == 0) begin
                r = hh; b = vv;
            end else begin
                b = hh; r = vv;
            end
            r = clamp_px(r);
            b = clamp_px(b);
        end else begin
            o7 = raw_px(x - 1, y - 1); o9 = raw_px(x + 1, y - 1);
            o17 = raw_px(x - 1, y + 1); o19 = raw_px(x + 1, y + 1);
            s1 = raw_px(x - 2, y - 2); s5 = raw_px(x + 2, y - 2);
            s21 = raw_px(x - 2, y + 2); s25 = raw_px(x + 2, y + 2);
            g7 = green_est(x - 1, y - 1); g9 = green_est(x + 1, y - 1);
            g17 = green_est(x - 1, y + 1); g19 = green_est(x + 1, y + 1);
            g0 = green_est(x, y);
            g = g0;
            dne = absi(o9 - o17) + absi(s5 - c) + absi(c - s21) + absi(g9 - g0)
                + absi(g0 - g17);
            dnw = absi(o7 - o19) + absi(s1 - c) + absi(c - s25) + absi(g7 - g0)
                + absi(g0 - g19);
            v = clamp_px(dne < dnw ? hue_transit(g9, g0, g17, o9, o17)
                                   : hue_transit(g7, g0, g19, o7, o19));
            if ((y & 1) == 0) begin
                r = c; b = v;
            end else begin
                b = c; r = v;
            end
        end
        p.red = r[7:0];
        p.green = g[7:0];
        p.blue = b[7:0];
        out_col++;
        if (out_col >= act_w) begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= act_h) begin
            p.frame_end = 1'b1;
            out_col = 0; out_row = 0; in_col = 0; in_row = 0;
        end else begin
            p.frame_end = 1'b0;
        end
        pixels_due.push_back(p);
    endfunction

    // Predictor update for one accepted item
    function automatic void predict_item(input logic [7:0] smp, input logic fl);
        int n;
        update_size();
        if (fl) begin
            if (in_row >= act_h && out_row < act_h) emit_pixel();
            return;
        end
        if (in_row >= act_h) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        line_mem[(in_row & 7) * MAXW + in_col] = smp;
        n = in_row * act_w + in_col;
        in_col++;
        if (in_col >= act_w) begin
            in_col = 0;
            in_row++;
        end
        if (n >= 3 * act_w + 1) emit_pixel();
    endfunction

    // Send one item, with an optional idle burst first
    task automatic send_item(input logic [7:0] smp, input logic fl);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = smp;
        s_tuser = fl;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        predict_item(smp, fl);
        items_sent++;
    endtask

    // Wait until every expected pixel has come and the block is idle
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = int'(val[11:0]);
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_reg = int'(val);
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        update_size();
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_size(input int w, input int h);
        if ($urandom_range(0, 1)) begin
            write_reg(REG_FRAME_WIDTH, w[CFG_DATA_W-1:0]);
            write_reg(REG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
        end else begin
            write_reg(REG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
            write_reg(REG_FRAME_WIDTH, w[CFG_DATA_W-1:0]);
        end
    endtask

    // Reset size: the start of a 640 x 480 frame yields no pixel yet
    task automatic test_reset_size();
        repeat (16) send_item(rnd_px(), 1'b0);
        send_item(8'd0, 1'b1);
    endtask

    // Small frames: extremes, flat data, flush mid frame, idle flush, new frame over a tail
    task automatic test_directed();
        set_size(3, 3);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b1);        // flush while the frame is arriving
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        repeat (9) send_item(8'd0, 1'b1);
        send_item(8'd0, 1'b1);        // nothing pending
        // flat frame: every gradient ties
        repeat (9) send_item(8'd128, 1'b0);
        repeat (4) send_item(8'd0, 1'b1);
        // sample over a pending tail starts a new frame
        repeat (9) send_item(8'hA5, 1'b0);
        repeat (9) send_item(8'd0, 1'b1);
    endtask

    // Register extremes and out-of-range values
    task automatic test_size_limits();
        set_size(0, 0);
        repeat (3) send_item(rnd_px(), 1'b0);
        send_item(8'd0, 1'b1);
        set_size(4095, 1);            // clipped to the widest row, row stays open
        repeat (16) send_item(rnd_px(), 1'b0);
        repeat (4) send_item(8'd0, 1'b1);
        set_size(1, 8191);            // clipped to the tallest frame
        repeat (24) send_item(rnd_px(), 1'b0);
        set_size(MAXW, MAXH);
        repeat (8) send_item(rnd_px(), 1'b0);
        write_reg(2'd2, 13'h1FFF);    // unused index: no effect
        write_reg(2'd3, 13'h0000);
        set_size(2, 4097);
        repeat (12) send_item(rnd_px(), 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        set_size(6, 6);
        hold_cnt = 2000;
        repeat (36) send_item(rnd_px(), 1'b0);
        repeat (19) send_item(8'd0, 1'b1);
        drain();
    endtask

    // Random frames with random content, some noise and cut tails
    task automatic test_random_frames(input int budget);
        int w, h, k, tail, stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 2) != 0) begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
                h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
                set_size(w, h);
            end
            if (items_sent > stop_at - budget / 4) idle_on = 1'b0;
            for (k = 0; k < act_w * act_h; k++) begin
                if ($urandom_range(0, 19) == 0) send_item(rnd_px(), 1'b1);
                send_item(rnd_px(), 1'b0);
            end
            tail = (act_w * act_h < 3 * act_w + 1) ? act_w * act_h : 3 * act_w + 1;
            if ($urandom_range(0, 4) == 0) tail = $urandom_range(0, tail);
            else if ($urandom_range(0, 3) == 0) tail = tail + $urandom_range(1, 3);
            repeat (tail) send_item(8'd0, 1'b1);
        end
    endtask

    // Output side: random stalls plus a long hold on request
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cnt > 0) begin
                m_tready = 1'b0;
                hold_cnt--;
            end else if (stall_cnt > 0) begin
                m_tready = 1'b0;
                stall_cnt--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                stall_cnt = $urandom_range(0, 5);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Result check against the oldest expected pixel
    always @(posedge aclk) begin
        pixel_t p;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixels_due.size() == 0) begin
                $error("unexpected pixel %h last %b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                p = pixels_due.pop_front();
                if (m_tdata[7:0] !== p.red) begin
                    $error("red: expected %0d, actual %0d", p.red, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== p.green) begin
                    $error("green: expected %0d, actual %0d", p.green, m_tdata[15:8]);
                    fail_count++;
                end
                if (m_tdata[23:16] !== p.blue) begin
                    $error("blue: expected %0d, actual %0d", p.blue, m_tdata[23:16]);
                    fail_count++;
                end
                if (m_tlast !== p.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", p.frame_end, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        items_sent = 0;
        hold_cnt = 0;
        idle_on = 1'b1;
        width_reg = int'(FRAME_WIDTH_RST);
        height_reg = int'(FRAME_HEIGHT_RST);
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        act_w = width_reg;
        act_h = height_reg;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_size();
        test_directed();
        test_size_limits();
        test_backpressure();
        idle_on = 1'b1;
        test_random_frames(1100);

        drain();
        if (fail_count == 0 && pixels_due.size() == 0)
            $display("bayer_ppg_demosaic_top verification clean");
        else
            $display("bayer_ppg_demosaic_top verification failed");
        $finish;
    end

endmodule
